FILE: hw/rtl/mrrc_pkg.sv
// shared types and constants for the motor ramp and reverse controller
package mrrc_pkg;

  // elapsed time above this only resyncs the timestamp
  localparam logic [31:0] RESYNC_LIMIT     = 32'd100000000;
  localparam logic [19:0] DEFAULT_INTERVAL = 20'd3000;
  localparam logic [6:0]  FULL_POWER       = 7'd100;

  // one input beat
  typedef struct packed {
    logic [31:0] time_us;
    logic [6:0]  target_power;
    logic        target_direction;
  } in_beat_t;

  // one result beat
  typedef struct packed {
    logic [6:0] power;
    logic [9:0] pwm_compare;
    logic       direction;
    logic       pin_a;
    logic       pin_b;
  } result_t;

endpackage

FILE: hw/rtl/mrrc_in_reg.sv
// input register stage that captures one beat ahead of the ramp update
module mrrc_in_reg
  import mrrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] time_us,
  input  logic [6:0]  target_power,
  input  logic        target_direction,
  input  logic        advance,
  output logic        held_valid,
  output in_beat_t    held_beat
);

  // slot frees when empty or when its beat moves on this cycle
  assign in_ready = !held_valid || advance;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_beat.time_us          <= time_us;
      held_beat.target_power     <= target_power;
      held_beat.target_direction <= target_direction;
    end
  end

endmodule

FILE: hw/rtl/mrrc_ramp_core.sv
// ramp state, interval register, per-beat update logic and compare table
module mrrc_ramp_core
  import mrrc_pkg::*;
#(
  parameter int unsigned PWM_PERIOD = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [19:0] cfg_data,
  input  logic        step,
  input  in_beat_t    beat,
  output result_t     res_next
);

  logic [19:0] ramp_interval;
  logic [6:0]  current_power;
  logic        applied_direction;
  logic        running;
  logic [31:0] last_change_time;
  logic        pin_a_level;
  logic        pin_b_level;

  logic [6:0]  current_power_next;
  logic        applied_direction_next;
  logic        running_next;
  logic [31:0] last_change_time_next;
  logic        pin_a_level_next;
  logic        pin_b_level_next;

  logic [6:0]  target;
  logic [31:0] elapsed;
  logic [9:0]  cmp_tbl [128];

  // compare value table, power * period / 100 worked out at elaboration
  for (genvar i = 0; i < 128; i++) begin : g_cmp
    localparam int unsigned CMP = (i * PWM_PERIOD) / 100;
    assign cmp_tbl[i] = CMP[9:0];
  end

  // clamp target and measure time since last change
  assign target  = (beat.target_power > FULL_POWER) ? FULL_POWER : beat.target_power;
  assign elapsed = beat.time_us - last_change_time;

  // ramp update
  always_comb begin
    current_power_next     = current_power;
    applied_direction_next = applied_direction;
    running_next           = running;
    last_change_time_next  = last_change_time;
    pin_a_level_next       = pin_a_level;
    pin_b_level_next       = pin_b_level;
    if (elapsed > RESYNC_LIMIT) begin
      last_change_time_next = beat.time_us;
    end else if (elapsed >= {12'd0, ramp_interval}) begin
      if (applied_direction != beat.target_direction) begin
        // reversal: ramp down first, then swap the bridge pins
        last_change_time_next = beat.time_us;
        if (current_power != 7'd0) begin
          current_power_next = current_power - 7'd1;
        end else begin
          applied_direction_next = beat.target_direction;
          pin_a_level_next       = beat.target_direction;
          pin_b_level_next       = !beat.target_direction;
        end
      end else if (current_power < target) begin
        last_change_time_next = beat.time_us;
        if (!running) begin
          running_next     = 1'b1;
          pin_a_level_next = beat.target_direction;
          pin_b_level_next = !beat.target_direction;
        end else begin
          current_power_next = current_power + 7'd1;
        end
      end else if (current_power > target) begin
        last_change_time_next = beat.time_us;
        current_power_next    = current_power - 7'd1;
        // stepping down to zero with a zero target also stops
        if (current_power == 7'd1 && target == 7'd0) begin
          running_next = 1'b0;
        end
      end else if (current_power == 7'd0) begin
        // power and target both zero: stop
        running_next          = 1'b0;
        last_change_time_next = beat.time_us;
      end
    end
  end

  // result as it stands after the update
  always_comb begin
    res_next.power       = current_power_next;
    res_next.pwm_compare = cmp_tbl[current_power_next];
    res_next.direction   = applied_direction_next;
    res_next.pin_a       = pin_a_level_next;
    res_next.pin_b       = pin_b_level_next;
  end

  // interval register
  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_interval <= DEFAULT_INTERVAL;
    end else if (cfg_valid) begin
      ramp_interval <= cfg_data;
    end
  end

  // ramp state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_power     <= 7'd0;
      applied_direction <= 1'b0;
      running           <= 1'b0;
      last_change_time  <= 32'd0;
      pin_a_level       <= 1'b0;
      pin_b_level       <= 1'b0;
    end else if (step) begin
      current_power     <= current_power_next;
      applied_direction <= applied_direction_next;
      running           <= running_next;
      last_change_time  <= last_change_time_next;
      pin_a_level       <= pin_a_level_next;
      pin_b_level       <= pin_b_level_next;
    end
  end

endmodule

FILE: hw/rtl/mrrc_out_reg.sv
// result register holding one beat until the consumer takes it
module mrrc_out_reg
  import mrrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t res_in,
  output logic    space,
  input  logic    out_ready,
  output logic    out_valid,
  output result_t res
);

  // free when empty or emptied this cycle
  assign space = !out_valid || out_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (space) begin
      out_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

FILE: hw/rtl/motor_ramp_reverse_controller_top.sv
// top level of the motor soft-start ramp and reverse controller
//
//   channel  signals                                        direction
//   in       in_valid/in_ready, time_us, target_power,      sink
//            target_direction
//   out      out_valid/out_ready, power, pwm_compare,       source
//            direction, pin_a, pin_b
//   cfg      cfg_valid/cfg_ready, cfg_data (ramp_interval)  sink
//
// one beat per cycle sustained while out_ready stays high; a result beat passes from the
// input register through the ramp update into the result register.
// reset clears the ramp state and sets ramp_interval to 3000 us.
// a stalled result holds in the output register; the input register keeps
// taking a beat as long as the result register frees up the same cycle.
// cfg_ready is always high.
module motor_ramp_reverse_controller_top
  import mrrc_pkg::*;
#(
  parameter int unsigned PWM_PERIOD = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] time_us,
  input  logic [6:0]  target_power,
  input  logic        target_direction,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  power,
  output logic [9:0]  pwm_compare,
  output logic        direction,
  output logic        pin_a,
  output logic        pin_b,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);

  logic     held_valid;
  in_beat_t held_beat;
  logic     space;
  logic     advance;
  result_t  res_next;
  result_t  res;

  assign cfg_ready = 1'b1;
  assign advance   = held_valid && space;

  mrrc_in_reg u_in_reg (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .time_us          (time_us),
    .target_power     (target_power),
    .target_direction (target_direction),
    .advance          (advance),
    .held_valid       (held_valid),
    .held_beat        (held_beat)
  );

  mrrc_ramp_core #(
    .PWM_PERIOD (PWM_PERIOD)
  ) u_ramp_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .step      (advance),
    .beat      (held_beat),
    .res_next  (res_next)
  );

  mrrc_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .res_in    (res_next),
    .space     (space),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res       (res)
  );

  // result fields to ports
  assign power       = res.power;
  assign pwm_compare = res.pwm_compare;
  assign direction   = res.direction;
  assign pin_a       = res.pin_a;
  assign pin_b       = res.pin_b;

endmodule
